// ===== rtl/core/zzs_pkg.sv =====
// Shared widths, types and helpers for the zigzag scan walk counter.
package zzs_pkg;

  localparam int COORD_BITS = 16;
  localparam int GRID_W     = 16;
  localparam int CELL_W     = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  // wide enough for coord + 1 without wrap and for the grid size
  localparam int CMP_W = (COORD_BITS + 1 > GRID_W) ? COORD_BITS + 1 : GRID_W;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [GRID_W-1:0]     grid_t;
  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_STEP_LIMIT = 2'd2
  } zzs_reg_t;

  typedef struct packed {
    grid_t grid_rows;
    grid_t grid_cols;
    cnt_t  step_limit;
  } zzs_cfg_t;

  typedef struct packed {
    cell_t cell_row;
    cell_t cell_col;
    logic  disjoint_bits;
    cnt_t  flagged_total;
    logic  walk_done;
  } zzs_result_t;

  localparam grid_t RST_GRID_ROWS  = GRID_W'(8);
  localparam grid_t RST_GRID_COLS  = GRID_W'(8);
  localparam cnt_t  RST_STEP_LIMIT = CNT_W'(64);

  function automatic logic [CMP_W-1:0] coord_ext(input coord_t c);
    return CMP_W'(c);
  endfunction

  function automatic cell_t cell_of(input coord_t c);
    logic [CMP_W-1:0] e;
    e = CMP_W'(c);
    return e[CELL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/zzs_ifs.sv =====
// Valid/ready channel interfaces: tick requests, results and register writes.
interface zzs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface zzs_out_if;
  import zzs_pkg::*;
  logic  valid;
  logic  ready;
  cell_t cell_row;
  cell_t cell_col;
  logic  disjoint_bits;
  cnt_t  flagged_total;
  logic  walk_done;

  modport source (output valid, output cell_row, output cell_col, output disjoint_bits,
                  output flagged_total, output walk_done, input ready);
  modport sink   (input valid, input cell_row, input cell_col, input disjoint_bits,
                  input flagged_total, input walk_done, output ready);
endinterface

interface zzs_cfg_if;
  import zzs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/zigzag_scan_walk_counter.sv =====
// Top level of the zigzag scan walk counter.
//
//   channel  dir  payload                                             accepted when
//   in_req   in   restart                                             valid & ready
//   out_res  out  cell_row, cell_col, disjoint_bits, flagged_total,   valid & ready
//                 walk_done
//   cfg_wr   in   index (0 rows, 1 cols, 2 step limit), data          valid & ready
//
// One request per clock while in_req.ready is high; its result is registered in the result
// buffer and appears on out_res once any earlier result is taken. The walk state advances
// in the cycle of acceptance, so requests run back to back. Reset (rst_n low, synchronous)
// returns the walk to the origin and the registers to 8 x 8 with a limit of 64.
// A two-entry result buffer holds one extra result while out_res stalls; in_req.ready drops
// only when both entries hold results. cfg_wr is always ready.
module zigzag_scan_walk_counter (
  input logic      clk,
  input logic      rst_n,
  zzs_in_if.sink   in_req,
  zzs_out_if.source out_res,
  zzs_cfg_if.sink  cfg_wr
);
  import zzs_pkg::*;

  zzs_cfg_t    cfg;
  zzs_result_t step_res, buf_res;
  logic        in_ready, push;

  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = in_ready;
  assign push         = in_req.valid && in_ready;

  zzs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr.valid),
    .wr_index (cfg_wr.index),
    .wr_data  (cfg_wr.data),
    .cfg      (cfg)
  );

  zzs_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (push),
    .restart (in_req.restart),
    .cfg     (cfg),
    .result  (step_res)
  );

  zzs_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (step_res),
    .in_ready  (in_ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .dout      (buf_res)
  );

  assign out_res.cell_row      = buf_res.cell_row;
  assign out_res.cell_col      = buf_res.cell_col;
  assign out_res.disjoint_bits = buf_res.disjoint_bits;
  assign out_res.flagged_total = buf_res.flagged_total;
  assign out_res.walk_done     = buf_res.walk_done;

endmodule

// ===== rtl/core/zzs_cfg_regs.sv =====
// Configuration register file: grid size and step limit.
module zzs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [zzs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [zzs_pkg::CFG_DATA_W-1:0] wr_data,
  output zzs_pkg::zzs_cfg_t              cfg
);
  import zzs_pkg::*;

  zzs_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (zzs_reg_t'(wr_index))
        REG_GRID_ROWS:  cfg_nxt.grid_rows  = wr_data[GRID_W-1:0];
        REG_GRID_COLS:  cfg_nxt.grid_cols  = wr_data[GRID_W-1:0];
        REG_STEP_LIMIT: cfg_nxt.step_limit = wr_data[CNT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_rows  <= RST_GRID_ROWS;
      cfg_r.grid_cols  <= RST_GRID_COLS;
      cfg_r.step_limit <= RST_STEP_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/zzs_walk.sv =====
// Walk state, next-position logic and result formation for one tick.
module zzs_walk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 restart,
  input  zzs_pkg::zzs_cfg_t    cfg,
  output zzs_pkg::zzs_result_t result
);
  import zzs_pkg::*;

  coord_t row_r, row_nxt, col_r, col_nxt;
  logic   up_r, up_nxt, pend_r, pend_nxt;
  cnt_t   steps_r, steps_nxt, flags_r, flags_nxt;

  coord_t           adv_row, adv_col;
  logic             adv_up, adv_pend;
  logic [CMP_W-1:0] row_p1, col_p1;
  logic             last_row, last_col;
  logic             flagged, lim_hit;
  cnt_t             steps_inc, flags_inc;

  assign row_p1   = coord_ext(row_r) + CMP_W'(1);
  assign col_p1   = coord_ext(col_r) + CMP_W'(1);
  assign last_row = row_p1 == CMP_W'(cfg.grid_rows);
  assign last_col = col_p1 == CMP_W'(cfg.grid_cols);

  // next cell of the zigzag; an edge step is always followed by one diagonal
  always_comb begin
    adv_row  = row_r;
    adv_col  = col_r;
    adv_up   = up_r;
    adv_pend = 1'b0;
    if (pend_r || !(( !up_r && (last_row || col_r == '0)) ||
                    (up_r && (last_col || row_r == '0)))) begin
      if (up_r) begin
        adv_row = row_r - COORD_BITS'(1);
        adv_col = col_r + COORD_BITS'(1);
      end else begin
        adv_row = row_r + COORD_BITS'(1);
        adv_col = col_r - COORD_BITS'(1);
      end
    end else if (!up_r && last_row) begin
      adv_col  = col_r + COORD_BITS'(1);
      adv_up   = 1'b1;
      adv_pend = 1'b1;
    end else if (!up_r) begin
      adv_row  = row_r + COORD_BITS'(1);
      adv_up   = 1'b1;
      adv_pend = 1'b1;
    end else if (last_col) begin
      adv_row  = row_r + COORD_BITS'(1);
      adv_up   = 1'b0;
      adv_pend = 1'b1;
    end else begin
      adv_col  = col_r + COORD_BITS'(1);
      adv_up   = 1'b0;
      adv_pend = 1'b1;
    end
  end

  assign flagged   = (row_r & col_r) == '0;
  assign lim_hit   = steps_r >= cfg.step_limit;
  assign steps_inc = (steps_r != '1) ? steps_r + CNT_W'(1) : steps_r;
  assign flags_inc = (flagged && flags_r != '1) ? flags_r + CNT_W'(1) : flags_r;

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    up_nxt    = up_r;
    pend_nxt  = pend_r;
    steps_nxt = steps_r;
    flags_nxt = flags_r;
    result    = '0;
    if (restart) begin
      row_nxt   = '0;
      col_nxt   = '0;
      up_nxt    = 1'b1;
      pend_nxt  = 1'b0;
      steps_nxt = '0;
      flags_nxt = '0;
    end else if (lim_hit) begin
      result.flagged_total = flags_r;
      result.walk_done     = 1'b1;
    end else begin
      result.cell_row      = cell_of(row_r);
      result.cell_col      = cell_of(col_r);
      result.disjoint_bits = flagged;
      result.flagged_total = flags_inc;
      steps_nxt = steps_inc;
      flags_nxt = flags_inc;
      // the visit that reaches the limit leaves the position where it is
      if (steps_inc < cfg.step_limit) begin
        row_nxt  = adv_row;
        col_nxt  = adv_col;
        up_nxt   = adv_up;
        pend_nxt = adv_pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      up_r    <= 1'b1;
      pend_r  <= 1'b0;
      steps_r <= '0;
      flags_r <= '0;
    end else if (step_en) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      up_r    <= up_nxt;
      pend_r  <= pend_nxt;
      steps_r <= steps_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

// ===== rtl/core/zzs_out_buf.sv =====
// Result register with a skid entry, so the request side sees a registered ready.
module zzs_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  zzs_pkg::zzs_result_t din,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output zzs_pkg::zzs_result_t dout
);
  import zzs_pkg::*;

  zzs_result_t main_r, main_nxt, skid_r, skid_nxt;
  logic        main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  logic        take;

  assign take = main_v_r && out_ready;

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      // no push possible while the skid entry is occupied
      if (take) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || take) begin
        main_nxt   = din;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = din;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign dout      = main_r;

endmodule

// ===== rtl/core/zzs_checker.sv =====
// Port-level checks for the zigzag scan walk counter, bound to the top level.
module zzs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [zzs_pkg::CELL_W-1:0] cell_row,
  input logic [zzs_pkg::CELL_W-1:0] cell_col,
  input logic                      disjoint_bits,
  input logic                      walk_done
);

  // a result once shown stays valid until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a done report carries no cell
  a_done_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && walk_done |-> cell_row == '0 && cell_col == '0 && !disjoint_bits)
    else $error("done report carries a cell");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && disjoint_bits |-> (cell_row & cell_col) == '0 && !walk_done)
    else $error("flag set on overlapping coordinates");

  // nothing survives a reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind zigzag_scan_walk_counter zzs_checker u_zzs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .cell_row      (out_res.cell_row),
  .cell_col      (out_res.cell_col),
  .disjoint_bits (out_res.disjoint_bits),
  .walk_done     (out_res.walk_done)
);
